/* sv/rc_filter_cascade_top_assert.svh */
// Assertion macros shared by the filter cascade RTL.
`ifndef RC_FILTER_CASCADE_TOP_ASSERT_SVH
`define RC_FILTER_CASCADE_TOP_ASSERT_SVH

// Consequence must hold in the same cycle.
`define RCF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc filter cascade: same-cycle check failed");

// Consequence must hold in the following cycle.
`define RCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc filter cascade: next-cycle check failed");

`endif

/* sv/rcf_pkg.sv */
// Shared types, constants and microcode table of the RC filter cascade.
package rcf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int Q_W      = 24;
   localparam int K_W      = 15;
   localparam int GAIN_W   = 16;
   localparam int STEP_W   = 3;
   localparam int CSR_IDX_W = 8;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGES = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_K = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 8'd3;

   // Filter modes (any mode with bit 1 set runs as bandpass)
   localparam logic [1:0] MODE_HP = 2'd0;
   localparam logic [1:0] MODE_LP = 2'd1;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_READ   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_LEAK   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_QUPD   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_OUTMUL = 3'd4;
   localparam logic [STEP_W-1:0] STEP_SAT    = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_READ,
      OP_LEAK,
      OP_QUPD,
      OP_OUTMUL,
      OP_SAT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_DONE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic                hold;    // stay on this step while the condition is false
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev;
      logic signed [Q_W-1:0]      q;
   } entry_type;

   localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = -24'sh800000;

   function automatic ctrl_word_type rcf_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:   w = '{OP_IDLE,   COND_REQ,      1'b1, STEP_READ};
         STEP_READ:   w = '{OP_READ,   COND_DONE,     1'b0, STEP_EMIT};
         STEP_LEAK:   w = '{OP_LEAK,   COND_ALWAYS,   1'b0, STEP_QUPD};
         STEP_QUPD:   w = '{OP_QUPD,   COND_ALWAYS,   1'b0, STEP_OUTMUL};
         STEP_OUTMUL: w = '{OP_OUTMUL, COND_ALWAYS,   1'b0, STEP_SAT};
         STEP_SAT:    w = '{OP_SAT,    COND_ALWAYS,   1'b0, STEP_READ};
         STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_FREE, 1'b1, STEP_IDLE};
         default:     w = '{OP_IDLE,   COND_ALWAYS,   1'b0, STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* sv/rcf_sequencer.sv */
// Microcode sequencer: step counter, control table lookup and section counter.
module rcf_sequencer #(
   parameter int MAX_STAGES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_fire,
   input  logic                                out_free,
   input  logic [$clog2(2*MAX_STAGES+1)-1:0]   total,
   output rcf_pkg::ctrl_word_type              ctrl,
   output logic [$clog2(2*MAX_STAGES+1)-1:0]   sec,
   output logic                                done
);
   import rcf_pkg::*;

   localparam int CW = $clog2(2*MAX_STAGES+1);

   logic [STEP_W-1:0] pc_ff, pc_in;
   logic [CW-1:0]     sec_ff, sec_in;
   logic              cond_true;

   assign ctrl = rcf_rom(pc_ff);
   assign sec  = sec_ff;
   assign done = (sec_ff == total);

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_REQ:      cond_true = req_fire;
         COND_DONE:     cond_true = done;
         COND_OUT_FREE: cond_true = out_free;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         pc_in = ctrl.target;
      end else if (ctrl.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 3'd1;
      end
   end

   always_comb begin
      case (ctrl.op)
         OP_IDLE: sec_in = '0;
         OP_SAT:  sec_in = sec_ff + 1'b1;
         default: sec_in = sec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_IDLE;
         sec_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         sec_ff <= sec_in;
      end
   end

`include "rc_filter_cascade_top_assert.svh"

   `RCF_ASSERT_NEXT(a_start_first_section, clock, reset, req_fire, (sec_ff == '0 && pc_ff == STEP_READ))
   `RCF_ASSERT_NEXT(a_sat_loops_back, clock, reset, (ctrl.op == OP_SAT), (pc_ff == STEP_READ && sec_ff == $past(sec_ff) + 1'b1))

endmodule

/* sv/rcf_state_mem.sv */
// Section state store: previous input and capacitor current per section.
module rcf_state_mem #(
   parameter int ENTRIES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic                        wr_en,
   input  logic [$clog2(ENTRIES)-1:0]  addr,
   input  rcf_pkg::entry_type          wr_data,
   output rcf_pkg::entry_type          rd_data
);
   import rcf_pkg::*;

   entry_type            mem_ff [ENTRIES];
   entry_type            rd_ff;
   logic                 rd_valid_ff;
   logic [ENTRIES-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   // never-written entries read as the cleared state
   assign rd_data = rd_valid_ff ? rd_ff : '0;

`include "rc_filter_cascade_top_assert.svh"

   `RCF_ASSERT_NEXT(a_write_marks_valid, clock, reset, wr_en, valid_ff[$past(addr)])

endmodule

/* sv/rcf_datapath.sv */
// Section arithmetic: leak multiply, current update, gain multiply, saturation.
module rcf_datapath (
   input  logic                                 clock,
   input  rcf_pkg::op_type                      op,
   input  logic                                 req_fire,
   input  logic [rcf_pkg::SAMPLE_W-1:0]         sample_in,
   input  logic [rcf_pkg::K_W-1:0]              coef_k,
   input  logic [rcf_pkg::GAIN_W-1:0]           gain,
   input  logic                                 lowpass,
   input  rcf_pkg::entry_type                   rd_data,
   output rcf_pkg::entry_type                   wr_data,
   output logic signed [rcf_pkg::SAMPLE_W-1:0]  x
);
   import rcf_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [16:0]         dx_ff, dx_in;
   logic signed [Q_W-1:0]      qold_ff;
   logic signed [39:0]         leak_ff, leak_in;
   logic signed [Q_W-1:0]      qnew_ff, qnew_in;
   logic signed [41:0]         prod_ff, prod_in;

   logic signed [39:0]         leak_rnd;
   logic signed [24:0]         leak_r;
   logic signed [26:0]         qsum;
   logic signed [24:0]         opnd;
   logic signed [41:0]         y_full;

   assign leak_in = rd_data.q * $signed({1'b0, coef_k});
   assign dx_in   = $signed({x_ff[15], x_ff}) - $signed({rd_data.prev[15], rd_data.prev});

   // round half up, then q + dx - leak with saturation to 24 bits
   assign leak_rnd = (leak_ff + 40'sd16384) >>> 15;
   assign leak_r   = leak_rnd[24:0];
   assign qsum     = $signed({{3{qold_ff[23]}}, qold_ff}) + $signed({{10{dx_ff[16]}}, dx_ff})
                   - $signed({{2{leak_r[24]}}, leak_r});

   always_comb begin
      if (qsum > $signed({{3{Q_MAX[23]}}, Q_MAX})) begin
         qnew_in = Q_MAX;
      end else if (qsum < $signed({{3{Q_MIN[23]}}, Q_MIN})) begin
         qnew_in = Q_MIN;
      end else begin
         qnew_in = qsum[23:0];
      end
   end

   assign wr_data = '{prev: x_ff, q: qnew_in};

   assign opnd    = lowpass ? ($signed({{9{x_ff[15]}}, x_ff}) - $signed({qnew_ff[23], qnew_ff}))
                            : $signed({qnew_ff[23], qnew_ff});
   assign prod_in = opnd * $signed({1'b0, gain});

   assign y_full = (prod_ff + 42'sd2048) >>> 12;

   always_comb begin
      x_in = x_ff;
      case (op)
         OP_IDLE: begin
            if (req_fire) begin
               x_in = $signed(sample_in);
            end
         end
         OP_SAT: begin
            if (y_full > 42'sd32767) begin
               x_in = 16'sh7FFF;
            end else if (y_full < -42'sd32768) begin
               x_in = -16'sh8000;
            end else begin
               x_in = y_full[15:0];
            end
         end
         default: x_in = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (op == OP_LEAK) begin
         leak_ff <= leak_in;
         dx_ff   <= dx_in;
         qold_ff <= rd_data.q;
      end
      if (op == OP_QUPD) begin
         qnew_ff <= qnew_in;
      end
      if (op == OP_OUTMUL) begin
         prod_ff <= prod_in;
      end
   end

   assign x = x_ff;

endmodule

/* sv/rc_filter_cascade_top.sv */
// RC filter cascade: a sample passes through up to MAX_STAGES first-order RC stages.
//
// req_ channel takes one signed 16-bit sample in tdata[15:0]; rsp_ channel returns
// one saturated 16-bit filtered sample per input in tdata[15:0]. The csr_ channel
// writes filter_mode (0), stages_used (1), coef_k (2) and gain (3); write only
// while no sample is in flight. csr_ready is high whenever reset is low.
// A microcoded sequencer runs five control steps per section on one shared
// datapath (state read, leak multiply, current update and write-back, gain
// multiply, round and saturate). With S sections in use (stages_used clipped to
// MAX_STAGES, doubled in bandpass mode) a sample runs through all S sections and
// goes to rsp_ from the emit step; no new sample is taken until the idle step.
// The result sits in an output register: the sequencer waits in its emit step
// only while that register is full and the receiver stalls.
// Reset clears all section state, loads the register reset values and returns
// the sequencer to its idle step; no clearing pass is needed.
module rc_filter_cascade_top #(
   parameter int MAX_STAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [15:0] sample_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [rcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import rcf_pkg::*;

   localparam int ENTRIES = 2 * MAX_STAGES;
   localparam int AW      = $clog2(ENTRIES);
   localparam int CW      = $clog2(2*MAX_STAGES+1);

   logic [1:0]        mode_ff;
   logic [3:0]        stages_ff;
   logic [K_W-1:0]    coef_k_ff;
   logic [GAIN_W-1:0] gain_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff;

   ctrl_word_type     ctrl;
   logic [CW-1:0]     sec;
   logic              done;
   logic [CW-1:0]     total;
   logic [5:0]        stages_ext, n_used;
   logic              hp_only, lp_only, lowpass;
   logic [AW-1:0]     addr;
   logic              req_fire, out_free, out_load;
   entry_type         rd_data, wr_data;
   logic signed [SAMPLE_W-1:0] x;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HP;
         stages_ff <= 4'd1;
         coef_k_ff <= 15'd1024;
         gain_ff   <= 16'd4096;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_data[1:0];
            CSR_STAGES: stages_ff <= csr_data[3:0];
            CSR_COEF_K: coef_k_ff <= csr_data[14:0];
            CSR_GAIN:   gain_ff   <= csr_data;
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   assign hp_only    = (mode_ff == MODE_HP);
   assign lp_only    = (mode_ff == MODE_LP);
   assign stages_ext = {2'b00, stages_ff};
   assign n_used     = (stages_ext > 6'(MAX_STAGES)) ? 6'(MAX_STAGES) : stages_ext;
   assign total      = (hp_only || lp_only) ? CW'(n_used) : CW'({n_used, 1'b0});

   // stage s keeps its highpass section at entry 2s and its lowpass one at 2s+1
   always_comb begin
      if (hp_only) begin
         addr    = AW'({sec, 1'b0});
         lowpass = 1'b0;
      end else if (lp_only) begin
         addr    = AW'({sec, 1'b1});
         lowpass = 1'b1;
      end else begin
         addr    = AW'(sec);
         lowpass = sec[0];
      end
   end

   assign req_tready = (ctrl.op == OP_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (ctrl.op == OP_EMIT) && out_free;

   rcf_sequencer #(
      .MAX_STAGES (MAX_STAGES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .total    (total),
      .ctrl     (ctrl),
      .sec      (sec),
      .done     (done)
   );

   rcf_state_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   ((ctrl.op == OP_READ) && !done),
      .wr_en   (ctrl.op == OP_QUPD),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   rcf_datapath u_dp (
      .clock     (clock),
      .op        (ctrl.op),
      .req_fire  (req_fire),
      .sample_in (req_tdata),
      .coef_k    (coef_k_ff),
      .gain      (gain_ff),
      .lowpass   (lowpass),
      .rd_data   (rd_data),
      .wr_data   (wr_data),
      .x         (x)
   );

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= x;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "rc_filter_cascade_top_assert.svh"

   `RCF_ASSERT_NEXT(a_taken_clears_output, clock, reset, (rsp_valid_ff && rsp_tready && !out_load), !rsp_tvalid)
   `RCF_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_fire, !req_tready)
   `RCF_ASSERT_SAME(a_emit_has_room, clock, reset, out_load, (!rsp_valid_ff || rsp_tready))

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the RC filter cascade: directed and random samples, scored per transfer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rcf_pkg::*;

   localparam int MAX_STAGES   = 8;
   localparam int SAMPLE_COUNT = 1850;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 5 * 2 * MAX_STAGES + 8;

   localparam logic [1:0] MODE_BP     = 2'd2;
   localparam logic [1:0] MODE_BP_ALT = 2'd3;

   localparam longint CAP_HI = 64'sd8388607;
   localparam longint CAP_LO = -64'sd8388608;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]          csr_data   = '0;

   // Filter settings and section state as the block should hold them
   logic [1:0]                 flt_mode;
   logic [3:0]                 flt_stages;
   logic [K_W-1:0]             flt_k;
   logic [GAIN_W-1:0]          flt_gain;
   logic signed [SAMPLE_W-1:0] prev_x [2*MAX_STAGES];
   logic signed [Q_W-1:0]      cap_q  [2*MAX_STAGES];

   logic signed [15:0] filtered_expected [$];
   logic [15:0]        sample_queue [$];

   int mismatches = 0;
   int accepted   = 0;
   int queued     = 0;
   int quiet_cycles;
   int req_gap;
   int rsp_stall;
   bit req_fire   = 1'b0;
   bit rsp_fire   = 1'b0;
   bit steady     = 1'b0;

   rc_filter_cascade_top #(
      .MAX_STAGES (MAX_STAGES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // One RC section: update the capacitor current, then scale the chosen output.
   function automatic logic signed [15:0] rc_section(int idx, logic signed [15:0] x,
                                                     bit lowpass);
      longint q;
      longint dx;
      longint leak;
      longint y;
      q    = longint'(cap_q[idx]);
      dx   = longint'(x) - longint'(prev_x[idx]);
      leak = (q * longint'(flt_k) + 64'sd16384) >>> 15;
      q    = q + dx - leak;
      if (q > CAP_HI) q = CAP_HI;
      if (q < CAP_LO) q = CAP_LO;
      cap_q[idx]  = q[Q_W-1:0];
      prev_x[idx] = x;
      if (lowpass)
         y = ((longint'(x) - q) * longint'(flt_gain) + 64'sd2048) >>> 12;
      else
         y = (q * longint'(flt_gain) + 64'sd2048) >>> 12;
      if (y > 64'sd32767) y = 64'sd32767;
      if (y < -64'sd32768) y = -64'sd32768;
      return y[15:0];
   endfunction

   function automatic logic signed [15:0] filter_sample(logic signed [15:0] x);
      int n;
      logic signed [15:0] y;
      n = (flt_stages > MAX_STAGES) ? MAX_STAGES : int'(flt_stages);
      y = x;
      for (int s = 0; s < n; s++) begin
         case (flt_mode)
            MODE_HP: y = rc_section(2 * s, y, 1'b0);
            MODE_LP: y = rc_section(2 * s + 1, y, 1'b1);
            default: begin
               y = rc_section(2 * s, y, 1'b0);
               y = rc_section(2 * s + 1, y, 1'b1);
            end
         endcase
      end
      return y;
   endfunction

   // Monitor: track register writes, predict on each request transfer, score responses.
   always @(posedge clock) begin : monitor
      logic signed [15:0] want;
      req_fire = req_tvalid && req_tready;
      rsp_fire = rsp_tvalid && rsp_tready;
      if (reset) begin
         flt_mode     = MODE_HP;
         flt_stages   = 4'd1;
         flt_k        = 15'd1024;
         flt_gain     = 16'd4096;
         quiet_cycles = 0;
         for (int i = 0; i < 2 * MAX_STAGES; i++) begin
            prev_x[i] = '0;
            cap_q[i]  = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:   flt_mode   = csr_data[1:0];
               CSR_STAGES: flt_stages = csr_data[3:0];
               CSR_COEF_K: flt_k      = csr_data[K_W-1:0];
               CSR_GAIN:   flt_gain   = csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            filtered_expected.push_back(filter_sample(req_tdata));
            accepted++;
         end
         if (rsp_fire) begin
            if (filtered_expected.size() == 0) begin
               $error("sample_out: expected none, actual %0d", $signed(rsp_tdata));
               mismatches++;
            end else begin
               want = filtered_expected.pop_front();
               if (rsp_tdata !== want) begin
                  $error("sample_out: expected %0d, actual %0d", want, $signed(rsp_tdata));
                  mismatches++;
               end
            end
         end
         if (req_fire || rsp_fire || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rc_filter_cascade_top: mismatch");
            $finish;
         end
      end
   end

   // Driver: hold a sample until its transfer, then idle for the drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (sample_queue.size() != 0) begin
            req_tdata  <= sample_queue.pop_front();
            req_tvalid <= 1'b1;
            req_gap = steady ? 0 : $urandom_range(0, 10);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: after each transfer, stall for a drawn number of cycles with a result waiting.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_fire)
            rsp_stall = steady ? 0 : $urandom_range(0, 10);
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            if (rsp_tvalid) rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write the selected registers; unused upper data bits carry random noise.
   task automatic program_filter(logic [1:0] m, logic [3:0] st, logic [14:0] k,
                                 logic [15:0] g, logic [3:0] which);
      if (which[0]) csr_write(CSR_MODE, (16'($urandom) & 16'hFFFC) | 16'(m));
      if (which[1]) csr_write(CSR_STAGES, (16'($urandom) & 16'hFFF0) | 16'(st));
      if (which[2]) csr_write(CSR_COEF_K, (16'($urandom) & 16'h8000) | 16'(k));
      if (which[3]) csr_write(CSR_GAIN, g);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_one(logic [15:0] s);
      sample_queue.push_back(s);
      queued++;
   endtask

   task automatic queue_random(int count);
      logic [15:0] s;
      s = '0;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: s = 16'($urandom_range(0, 511)) - 16'd256;
            2: ;  // hold the last sample so the sections settle
            3: s = s + 16'($urandom_range(0, 63)) - 16'd32;
            default: s = 16'($urandom);
         endcase
         queue_one(s);
      end
   endtask

   // Wait until every queued sample has gone in and its result has come back.
   task automatic settle();
      do @(negedge clock); while (accepted != queued || filtered_expected.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      logic [3:0]  st;
      logic [14:0] k;
      logic [15:0] g;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register reset values: one highpass section at unity gain
      queue_one(16'h7FFF);
      queue_one(16'h8000);
      queue_one(16'h0000);
      queue_one(16'h0001);
      queue_one(16'hFFFF);
      queue_one(16'h5555);
      queue_one(16'hAAAA);
      settle();

      // Full lowpass cascade, strongest leak, top gain: drive the outputs into saturation
      program_filter(MODE_LP, 4'd8, 15'd32767, 16'hFFFF, 4'hF);
      queue_one(16'h7FFF);
      queue_one(16'h8000);
      queue_one(16'h8000);
      queue_one(16'h7FFF);
      settle();

      // Bandpass with a stage count above the maximum, no leak, zero gain
      program_filter(MODE_BP, 4'd15, 15'd0, 16'h0000, 4'hF);
      queue_one(16'd1000);
      queue_one(-16'sd1000);
      queue_one(16'h7FFF);
      settle();

      // Mode three runs as bandpass
      program_filter(MODE_BP_ALT, 4'd3, 15'd1, 16'hFFFF, 4'hF);
      queue_one(16'h8000);
      queue_one(16'h7FFF);
      queue_one(16'h0123);
      settle();

      // No stages: samples pass straight through and no state moves
      program_filter(MODE_BP_ALT, 4'd0, 15'd1, 16'hFFFF, 4'b0010);
      queue_one(16'h8001);
      queue_one(16'h7FFE);
      settle();

      // Fewer stages: the idle sections must keep what they held
      program_filter(MODE_HP, 4'd2, 15'd4000, 16'd8192, 4'hF);
      queue_one(16'h4000);
      queue_one(16'hC000);
      queue_one(16'h0000);
      settle();

      while (queued < SAMPLE_COUNT) begin
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0:       st = 4'd0;
            1:       st = 4'($urandom_range(MAX_STAGES + 1, 15));
            default: st = 4'($urandom_range(1, MAX_STAGES));
         endcase
         case ($urandom_range(0, 7))
            0:       k = 15'd0;
            1:       k = 15'd32767;
            2:       k = 15'($urandom_range(0, 255));
            default: k = 15'($urandom_range(0, 32767));
         endcase
         case ($urandom_range(0, 7))
            0:       g = 16'h0000;
            1:       g = 16'hFFFF;
            2:       g = 16'd4096;
            default: g = 16'($urandom);
         endcase
         program_filter(2'($urandom_range(0, 3)), st, k, g, 4'($urandom_range(1, 15)));
         queue_random($urandom_range(20, 80));
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("rc_filter_cascade_top: match");
      else
         $display("rc_filter_cascade_top: mismatch");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/rcf_pkg.sv
sv/rcf_sequencer.sv
sv/rcf_state_mem.sv
sv/rcf_datapath.sv
sv/rc_filter_cascade_top.sv
dv/tb_top.sv
